FILE: hdl/ttmt_pkg.sv
// shared types and constants for the tick-to-microsecond timebase
// no dependencies; used by ttmt_div and tick_to_microsecond_timebase_top

package ttmt_pkg;

  // range limit for the reduced ratio: divisor and product stay below 2^RANGE_LIMIT_BITS
  localparam int unsigned RANGE_LIMIT_BITS = 38;

  // field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned FREQ_W    = 32;
  localparam int unsigned RATE_W    = 30;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DIV_CNT_W = 6;

  // reset values of the configuration registers
  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;
  localparam logic [RATE_W-1:0] RATE_RESET = 30'd1000000;

  // request operations
  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_ADD    = 2'd1,
    OP_START  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTER_FREQ = 1'b0,
    CFG_TARGET_RATE  = 1'b1
  } cfg_idx_t;

  // odd factors tried during ratio reduction
  typedef enum logic [1:0] {
    FAC_3 = 2'd0,
    FAC_5 = 2'd1,
    FAC_7 = 2'd2
  } fac_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMP_LO,
    ST_SMP_HI,
    ST_SMP_ADD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FAC_TWO,
    ST_FAC_NUM,
    ST_FAC_DIV,
    ST_FAC_CHK,
    ST_RNG_MUL,
    ST_RNG_CHK,
    ST_RESULT
  } state_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // multiplicative inverse of the factor modulo 2^32
  function automatic logic [31:0] fac_inv(fac_t f);
    logic [31:0] v;
    unique case (f)
      FAC_3:   v = 32'hAAAA_AAAB;
      FAC_5:   v = 32'hCCCC_CCCD;
      FAC_7:   v = 32'hB6DB_6DB7;
      default: v = 32'h0000_0001;
    endcase
    return v;
  endfunction

  // largest quotient (2^32-1)/f: n*inv mod 2^32 at or below it means f divides n
  function automatic logic [31:0] fac_lim(fac_t f);
    logic [31:0] v;
    unique case (f)
      FAC_3:   v = 32'h5555_5555;
      FAC_5:   v = 32'h3333_3333;
      FAC_7:   v = 32'h2492_4924;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/ttmt_div.sv
// iterative restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle
// depends on ttmt_pkg

module ttmt_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ttmt_pkg::TIME_W-1:0]     dividend,
  input  logic [ttmt_pkg::FREQ_W-1:0]     divisor,
  output logic [ttmt_pkg::TIME_W-1:0]     quotient,
  output ttmt_pkg::div_stat_t             stat
);

  logic [ttmt_pkg::TIME_W-1:0]    q_r;
  logic [ttmt_pkg::FREQ_W-1:0]    rem_r;
  logic [ttmt_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [ttmt_pkg::FREQ_W:0]      rem_sh;
  logic [ttmt_pkg::FREQ_W:0]      diff;
  logic                           ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_r, q_r[ttmt_pkg::TIME_W-1]};
    ge     = rem_sh >= {1'b0, divisor};
    diff   = rem_sh - {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + ttmt_pkg::DIV_CNT_W'(1);
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[ttmt_pkg::TIME_W-2:0], ge};
      rem_r <= ge ? diff[ttmt_pkg::FREQ_W-1:0] : rem_sh[ttmt_pkg::FREQ_W-1:0];
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: hdl/tick_to_microsecond_timebase_top.sv
// tick-to-microsecond timebase: sequencer, shared 32x32 multiplier and state registers
// depends on ttmt_pkg and ttmt_div

// Converts raw free-running counter readings into elapsed time units. A start
// request captures the zero point and loads target_rate/counter_freq, then reduces
// the ratio by 2, 3, 5 and 7 and halves it until divisor and product fit the range
// limit. A sample request returns ((counter - zero) * numerator mod 2^64) / divisor
// and caches it; add and read requests return the cached value, and every result
// also carries that value plus the wrapping offset. One request is worked at a
// time and in_stall is high meanwhile; a finished result waits in the output
// register while the next request is taken. A sample runs through the accept,
// two passes through the shared 32x32 multiplier plus an add, a divider start,
// 64 one-bit steps of the restoring divider, storing the quotient and the result
// state; add and read go from the accept to the result state. A start runs the
// reduction loop between the accept and the result state: a test per factor of 2,
// multiplies of numerator and divisor by the inverse and a check per odd factor
// tried, a multiply and a check per range check. The result state repeats while
// the output register holds an unaccepted result; config writes are always taken.

module tick_to_microsecond_timebase_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ttmt_pkg::OP_W-1:0]         in_op,
  input  logic [ttmt_pkg::TIME_W-1:0]       in_counter_value,
  input  logic [ttmt_pkg::TIME_W-1:0]       in_offset_add,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ttmt_pkg::TIME_W-1:0]       out_realtime_us,
  output logic [ttmt_pkg::TIME_W-1:0]       out_time_us,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ttmt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttmt_pkg::FREQ_W-1:0]       cfg_data
);

  ttmt_pkg::state_t               state_r, state_nxt;
  ttmt_pkg::fac_t                 fac_r;

  logic [ttmt_pkg::FREQ_W-1:0]    freq_r;
  logic [ttmt_pkg::RATE_W-1:0]    rate_r;
  logic [ttmt_pkg::RATE_W-1:0]    num_r;
  logic [ttmt_pkg::FREQ_W-1:0]    div_r;
  logic [ttmt_pkg::TIME_W-1:0]    zero_r;
  logic [ttmt_pkg::TIME_W-1:0]    offset_r;
  logic [ttmt_pkg::TIME_W-1:0]    cached_r;

  logic [ttmt_pkg::TIME_W-1:0]    delta_r;
  logic [ttmt_pkg::TIME_W-1:0]    acc_r;
  logic [ttmt_pkg::TIME_W-1:0]    mul_r;
  logic [ttmt_pkg::FREQ_W-1:0]    tq_r;

  logic                           out_valid_r;
  logic [ttmt_pkg::TIME_W-1:0]    out_real_r;
  logic [ttmt_pkg::TIME_W-1:0]    out_time_r;

  logic [ttmt_pkg::FREQ_W-1:0]    mul_a;
  logic [ttmt_pkg::FREQ_W-1:0]    mul_b;
  logic                           div_start;
  logic [ttmt_pkg::TIME_W-1:0]    div_quot;
  ttmt_pkg::div_stat_t            div_stat;

  logic                           in_take;
  logic                           out_load;
  logic                           both_zero;
  logic                           two_hit;
  logic                           fac_hit;
  logic                           rng_over;
  logic [ttmt_pkg::FREQ_W-1:0]    lim;

  // handshakes
  assign in_take   = in_valid && !in_stall;
  assign out_load  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // reduction conditions
  always_comb begin
    lim       = ttmt_pkg::fac_lim(fac_r);
    both_zero = (num_r == '0) && (div_r == '0);
    two_hit   = !num_r[0] && !div_r[0];
    fac_hit   = (tq_r <= lim) && (mul_r[ttmt_pkg::FREQ_W-1:0] <= lim);
    rng_over  = (({{ttmt_pkg::FREQ_W{1'b0}}, div_r} >> ttmt_pkg::RANGE_LIMIT_BITS) != '0)
             || ((mul_r >> ttmt_pkg::RANGE_LIMIT_BITS) != '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttmt_pkg::ST_IDLE: begin
        if (in_take) begin
          unique case (ttmt_pkg::op_t'(in_op))
            ttmt_pkg::OP_SAMPLE: state_nxt = ttmt_pkg::ST_SMP_LO;
            ttmt_pkg::OP_START:  state_nxt = ttmt_pkg::ST_FAC_TWO;
            ttmt_pkg::OP_ADD:    state_nxt = ttmt_pkg::ST_RESULT;
            ttmt_pkg::OP_READ:   state_nxt = ttmt_pkg::ST_RESULT;
            default:             state_nxt = ttmt_pkg::ST_RESULT;
          endcase
        end
      end
      ttmt_pkg::ST_SMP_LO:  state_nxt = ttmt_pkg::ST_SMP_HI;
      ttmt_pkg::ST_SMP_HI:  state_nxt = ttmt_pkg::ST_SMP_ADD;
      ttmt_pkg::ST_SMP_ADD: state_nxt = ttmt_pkg::ST_DIV_GO;
      ttmt_pkg::ST_DIV_GO:  state_nxt = ttmt_pkg::ST_DIV_WAIT;
      ttmt_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) state_nxt = ttmt_pkg::ST_RESULT;
      end
      ttmt_pkg::ST_FAC_TWO: begin
        priority if (both_zero) state_nxt = ttmt_pkg::ST_RNG_MUL;
        else if (two_hit)       state_nxt = ttmt_pkg::ST_FAC_TWO;
        else                    state_nxt = ttmt_pkg::ST_FAC_NUM;
      end
      ttmt_pkg::ST_FAC_NUM: state_nxt = ttmt_pkg::ST_FAC_DIV;
      ttmt_pkg::ST_FAC_DIV: state_nxt = ttmt_pkg::ST_FAC_CHK;
      ttmt_pkg::ST_FAC_CHK: begin
        priority if (fac_hit)               state_nxt = ttmt_pkg::ST_FAC_TWO;
        else if (fac_r == ttmt_pkg::FAC_7)  state_nxt = ttmt_pkg::ST_RNG_MUL;
        else                                state_nxt = ttmt_pkg::ST_FAC_NUM;
      end
      ttmt_pkg::ST_RNG_MUL: state_nxt = ttmt_pkg::ST_RNG_CHK;
      ttmt_pkg::ST_RNG_CHK: begin
        if (rng_over) state_nxt = ttmt_pkg::ST_FAC_TWO;
        else          state_nxt = ttmt_pkg::ST_RESULT;
      end
      ttmt_pkg::ST_RESULT: begin
        if (out_load) state_nxt = ttmt_pkg::ST_IDLE;
      end
      default: state_nxt = ttmt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: stall, multiplier operands, divider start
  always_comb begin
    in_stall  = (state_r != ttmt_pkg::ST_IDLE);
    div_start = (state_r == ttmt_pkg::ST_DIV_GO);
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ttmt_pkg::ST_SMP_LO: begin
        mul_a = delta_r[ttmt_pkg::FREQ_W-1:0];
        mul_b = {2'b00, num_r};
      end
      ttmt_pkg::ST_SMP_HI: begin
        mul_a = delta_r[ttmt_pkg::TIME_W-1:ttmt_pkg::FREQ_W];
        mul_b = {2'b00, num_r};
      end
      ttmt_pkg::ST_FAC_NUM: begin
        mul_a = {2'b00, num_r};
        mul_b = ttmt_pkg::fac_inv(fac_r);
      end
      ttmt_pkg::ST_FAC_DIV: begin
        mul_a = div_r;
        mul_b = ttmt_pkg::fac_inv(fac_r);
      end
      ttmt_pkg::ST_RNG_MUL: begin
        mul_a = {2'b00, num_r};
        mul_b = div_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ttmt_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= ttmt_pkg::FREQ_RESET;
      rate_r <= ttmt_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ttmt_pkg::cfg_idx_t'(cfg_index))
        ttmt_pkg::CFG_COUNTER_FREQ: freq_r <= cfg_data;
        ttmt_pkg::CFG_TARGET_RATE:  rate_r <= cfg_data[ttmt_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // timebase state: ratio, zero point, offset, cache, factor pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r    <= '0;
      div_r    <= {{(ttmt_pkg::FREQ_W-1){1'b0}}, 1'b1};
      zero_r   <= '0;
      offset_r <= '0;
      cached_r <= '0;
      fac_r    <= ttmt_pkg::FAC_3;
    end else begin
      unique case (state_r)
        ttmt_pkg::ST_IDLE: begin
          if (in_take) begin
            if (ttmt_pkg::op_t'(in_op) == ttmt_pkg::OP_ADD) begin
              offset_r <= offset_r + in_offset_add;
            end
            if (ttmt_pkg::op_t'(in_op) == ttmt_pkg::OP_START) begin
              num_r  <= rate_r;
              div_r  <= freq_r;
              zero_r <= in_counter_value;
            end
          end
        end
        ttmt_pkg::ST_DIV_WAIT: begin
          if (div_stat.done) cached_r <= div_quot;
        end
        ttmt_pkg::ST_FAC_TWO: begin
          if (!both_zero && two_hit) begin
            num_r <= num_r >> 1;
            div_r <= div_r >> 1;
          end
          fac_r <= ttmt_pkg::FAC_3;
        end
        ttmt_pkg::ST_FAC_CHK: begin
          priority if (fac_hit) begin
            num_r <= tq_r[ttmt_pkg::RATE_W-1:0];
            div_r <= mul_r[ttmt_pkg::FREQ_W-1:0];
          end else if (fac_r == ttmt_pkg::FAC_3) begin
            fac_r <= ttmt_pkg::FAC_5;
          end else if (fac_r == ttmt_pkg::FAC_5) begin
            fac_r <= ttmt_pkg::FAC_7;
          end
        end
        ttmt_pkg::ST_RNG_CHK: begin
          if (rng_over) begin
            num_r <= num_r >> 1;
            div_r <= div_r >> 1;
          end
        end
        default: ;
      endcase
    end
  end

  // shared multiplier and sample datapath
  always_ff @(posedge clk) begin
    mul_r <= {{ttmt_pkg::FREQ_W{1'b0}}, mul_a} * {{ttmt_pkg::FREQ_W{1'b0}}, mul_b};
    if (in_take) delta_r <= in_counter_value - zero_r;
    if (state_r == ttmt_pkg::ST_SMP_HI) acc_r <= mul_r;
    if (state_r == ttmt_pkg::ST_SMP_ADD) begin
      acc_r <= acc_r + {mul_r[ttmt_pkg::FREQ_W-1:0], {ttmt_pkg::FREQ_W{1'b0}}};
    end
    if (state_r == ttmt_pkg::ST_FAC_DIV) tq_r <= mul_r[ttmt_pkg::FREQ_W-1:0];
  end

  // divider
  ttmt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (div_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ttmt_pkg::ST_RESULT && out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ttmt_pkg::ST_RESULT && out_load) begin
      out_real_r <= cached_r;
      out_time_r <= cached_r + offset_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_realtime_us = out_real_r;
  assign out_time_us     = out_time_r;

  // a request is only taken while the divider is quiet
  a_take_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !div_stat.busy)
    else $error("request taken while divider busy");

  // a zero divisor yields an all-ones quotient
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.done && div_r == '0) |-> (div_quot == '1))
    else $error("zero divisor did not saturate quotient");

  // the odd factor check sees both products from the multiplier
  a_fac_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ttmt_pkg::ST_FAC_CHK) |-> ($past(state_r) == ttmt_pkg::ST_FAC_DIV))
    else $error("factor check out of sequence");

endmodule

FILE: sim/testbench.sv
// testbench for tick_to_microsecond_timebase_top: directed and random requests checked
// field by field against a behavioral predictor of the timebase
// depends on ttmt_pkg and tick_to_microsecond_timebase_top

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 215;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    ttmt_pkg::op_t                   op;
    logic [ttmt_pkg::TIME_W-1:0]     realtime_us;
    logic [ttmt_pkg::TIME_W-1:0]     time_us;
  } reading_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [ttmt_pkg::OP_W-1:0]         in_op = ttmt_pkg::OP_SAMPLE;
  logic [ttmt_pkg::TIME_W-1:0]       in_counter_value = '0;
  logic [ttmt_pkg::TIME_W-1:0]       in_offset_add = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [ttmt_pkg::TIME_W-1:0]       out_realtime_us;
  logic [ttmt_pkg::TIME_W-1:0]       out_time_us;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [ttmt_pkg::CFG_IDX_W-1:0]    cfg_index = ttmt_pkg::CFG_COUNTER_FREQ;
  logic [ttmt_pkg::FREQ_W-1:0]       cfg_data = '0;

  // predictor state: registers, reduced ratio, zero point, offset, cached value
  logic [ttmt_pkg::FREQ_W-1:0] freq_reg = ttmt_pkg::FREQ_RESET;
  logic [ttmt_pkg::RATE_W-1:0] rate_reg = ttmt_pkg::RATE_RESET;
  logic [63:0]                 scale_num = '0;
  logic [63:0]                 scale_den = 64'd1;
  logic [63:0]                 epoch = '0;
  logic [63:0]                 bias = '0;
  logic [63:0]                 last_elapsed = '0;

  reading_t pending_readings[$];
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  int       hold_requests = 0;
  bit       input_idle_on = 1'b1;
  bit       output_idle_on = 1'b1;

  tick_to_microsecond_timebase_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_counter_value (in_counter_value),
    .in_offset_add    (in_offset_add),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_realtime_us  (out_realtime_us),
    .out_time_us      (out_time_us),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // random helpers
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] pick_offset();
    if ($urandom_range(0, 1) == 0) return 64'($urandom_range(0, 1000));
    return rand64();
  endfunction

  function automatic logic [31:0] pick_freq();
    case ($urandom_range(0, 6))
      0:       return 32'd1;
      1:       return 32'hFFFF_FFFF;
      2:       return ttmt_pkg::FREQ_RESET;
      3:       return 32'd32768;
      4:       return 32'd24000000;
      default: return $urandom_range(1, 32'hFFFF_FFFF);
    endcase
  endfunction

  // upper two bits of the write data are not part of the rate register
  function automatic logic [31:0] pick_rate();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0:       v = 32'd1;
      1:       v = 32'd1000000000;
      2:       v = 32'(ttmt_pkg::RATE_RESET);
      3:       v = 32'd1000;
      default: v = $urandom_range(1, 1000000000);
    endcase
    v[31:30] = 2'($urandom_range(0, 3));
    return v;
  endfunction

  // mismatch reporting
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns %s: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // strip common factors 2, 3, 5, 7, halve while out of range
  task automatic reduce_scale();
    logic [63:0] limit;
    bit          stripped;
    limit = 64'd1 << ttmt_pkg::RANGE_LIMIT_BITS;
    forever begin
      stripped = (scale_num != 0 || scale_den != 0);
      while (stripped) begin
        if (scale_num % 2 == 0 && scale_den % 2 == 0) begin
          scale_num = scale_num / 2;
          scale_den = scale_den / 2;
        end else if (scale_num % 3 == 0 && scale_den % 3 == 0) begin
          scale_num = scale_num / 3;
          scale_den = scale_den / 3;
        end else if (scale_num % 5 == 0 && scale_den % 5 == 0) begin
          scale_num = scale_num / 5;
          scale_den = scale_den / 5;
        end else if (scale_num % 7 == 0 && scale_den % 7 == 0) begin
          scale_num = scale_num / 7;
          scale_den = scale_den / 7;
        end else begin
          stripped = 1'b0;
        end
      end
      if (scale_den >= limit || scale_num * scale_den >= limit) begin
        scale_num = scale_num >> 1;
        scale_den = scale_den >> 1;
      end else begin
        break;
      end
    end
  endtask

  // update the timebase for one accepted request and queue its reading
  task automatic predict_reading(ttmt_pkg::op_t op, logic [63:0] counter,
                                 logic [63:0] offset);
    reading_t r;
    case (op)
      ttmt_pkg::OP_SAMPLE: begin
        last_elapsed = (scale_den != 0) ? ((counter - epoch) * scale_num) / scale_den : '1;
      end
      ttmt_pkg::OP_ADD: bias = bias + offset;
      ttmt_pkg::OP_START: begin
        scale_num = 64'(rate_reg);
        scale_den = 64'(freq_reg);
        reduce_scale();
        epoch = counter;
      end
      default: ;
    endcase
    r.op = op;
    r.realtime_us = last_elapsed;
    r.time_us = last_elapsed + bias;
    pending_readings.push_back(r);
  endtask

  // one request; valid stays high into the next call unless a gap is drawn
  task automatic send_request(ttmt_pkg::op_t op, logic [63:0] counter, logic [63:0] offset);
    int gap;
    gap = input_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_counter_value <= counter;
    in_offset_add <= offset;
    do @(posedge clk); while (in_stall);
    predict_reading(op, counter, offset);
  endtask

  // stop sending and wait for every pending reading
  task automatic drain_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  task automatic write_register(ttmt_pkg::cfg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ttmt_pkg::CFG_COUNTER_FREQ) freq_reg = data;
    else rate_reg = data[ttmt_pkg::RATE_W-1:0];
  endtask

  // both registers back to back, block idle
  task automatic configure(logic [31:0] freq, logic [31:0] rate);
    write_register(ttmt_pkg::CFG_COUNTER_FREQ, freq);
    write_register(ttmt_pkg::CFG_TARGET_RATE, rate);
    cfg_valid <= 1'b0;
  endtask

  // numerator still zero before the first start
  task automatic test_before_start();
    send_request(ttmt_pkg::OP_SAMPLE, 64'd0, rand64());
    send_request(ttmt_pkg::OP_ADD, rand64(), '1);
    send_request(ttmt_pkg::OP_READ, rand64(), rand64());
    send_request(ttmt_pkg::OP_SAMPLE, '1, 64'd0);
  endtask

  // reset ratio 1/10: exact, wrapped delta, offset wrap, cache reuse
  task automatic test_default_ratio();
    send_request(ttmt_pkg::OP_START, 64'd1000, rand64());
    send_request(ttmt_pkg::OP_SAMPLE, 64'd1010, rand64());
    send_request(ttmt_pkg::OP_SAMPLE, 64'd999, rand64());
    send_request(ttmt_pkg::OP_ADD, rand64(), 64'd1);
    send_request(ttmt_pkg::OP_READ, rand64(), rand64());
    send_request(ttmt_pkg::OP_SAMPLE, '1, rand64());
    send_request(ttmt_pkg::OP_START, '1, rand64());
    send_request(ttmt_pkg::OP_SAMPLE, 64'd0, rand64());
  endtask

  // zero divisor, both terms zero, zero numerator, heavy range halving
  task automatic test_ratio_extremes();
    drain_readings();
    configure(32'd0, 32'(ttmt_pkg::RATE_RESET));
    send_request(ttmt_pkg::OP_START, rand64(), rand64());
    send_request(ttmt_pkg::OP_SAMPLE, rand64(), rand64());
    drain_readings();
    configure(32'd0, 32'hC000_0000);
    send_request(ttmt_pkg::OP_START, rand64(), rand64());
    send_request(ttmt_pkg::OP_SAMPLE, rand64(), rand64());
    drain_readings();
    configure(ttmt_pkg::FREQ_RESET, 32'h4000_0000);
    send_request(ttmt_pkg::OP_START, rand64(), rand64());
    send_request(ttmt_pkg::OP_SAMPLE, rand64(), rand64());
    drain_readings();
    configure(32'hFFFF_FFFF, 32'd1000000000);
    send_request(ttmt_pkg::OP_START, 64'd0, rand64());
    send_request(ttmt_pkg::OP_SAMPLE, 64'hFFFF_FFFF_FFFF, rand64());
  endtask

  // receiver holds off while samples keep coming, block fills and stalls
  task automatic test_backpressure();
    logic [63:0] base;
    drain_readings();
    configure(ttmt_pkg::FREQ_RESET, 32'(ttmt_pkg::RATE_RESET));
    base = rand64();
    input_idle_on = 1'b0;
    send_request(ttmt_pkg::OP_START, base, rand64());
    hold_requests++;
    for (int k = 0; k < 14; k++)
      send_request(ttmt_pkg::OP_SAMPLE, base + (rand64() >> $urandom_range(8, 63)),
                   rand64());
    input_idle_on = 1'b1;
    drain_readings();
  endtask

  // start-led runs of samples, adds and reads, plus random noise requests
  task automatic test_random_traffic();
    int          sent;
    int          run_len;
    logic [63:0] base;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_readings();
      case (phase)
        0:       configure(ttmt_pkg::FREQ_RESET, 32'(ttmt_pkg::RATE_RESET));
        1:       configure(32'd1, 32'd1000000000);
        2:       configure(32'hFFFF_FFFF, 32'd1);
        default: configure(pick_freq(), pick_rate());
      endcase
      input_idle_on = (phase != 0);
      output_idle_on = (phase != 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          base = rand64();
          send_request(ttmt_pkg::OP_START, base, rand64());
          run_len = $urandom_range(3, 12);
          for (int k = 0; k < run_len; k++) begin
            case ($urandom_range(0, 9))
              0, 1:    send_request(ttmt_pkg::OP_ADD, rand64(), pick_offset());
              2:       send_request(ttmt_pkg::OP_READ, rand64(), rand64());
              default: send_request(ttmt_pkg::OP_SAMPLE,
                                    base + (rand64() >> $urandom_range(0, 63)), rand64());
            endcase
          end
          sent += run_len + 1;
        end else begin
          send_request(ttmt_pkg::op_t'($urandom_range(0, 3)), rand64(), rand64());
          sent++;
        end
      end
    end
    input_idle_on = 1'b1;
    output_idle_on = 1'b1;
  endtask

  // result stall: long holds on request, otherwise random short and long stalls when output_idle_on
  initial begin : result_stall
    int served;
    int n;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (output_idle_on && $urandom_range(0, 4) == 0) begin
        n = pick_gap() + 1;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // compare each accepted result with the oldest pending reading
  always @(posedge clk) begin : check_results
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result with no request pending", out_realtime_us, '0);
      end else begin
        want = pending_readings.pop_front();
        if (out_realtime_us !== want.realtime_us)
          report_mismatch($sformatf("%s realtime_us", want.op.name()),
                          out_realtime_us, want.realtime_us);
        if (out_time_us !== want.time_us)
          report_mismatch($sformatf("%s time_us", want.op.name()),
                          out_time_us, want.time_us);
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tick_to_microsecond_timebase_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_before_start();
    test_default_ratio();
    test_ratio_extremes();
    test_backpressure();
    test_random_traffic();
    drain_readings();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_readings.size() == 0) begin
      $display("tick_to_microsecond_timebase_top: match");
    end else begin
      $display("tick_to_microsecond_timebase_top: mismatch");
    end
    $finish;
  end

endmodule
